>>> hdl/lfcr_pkg.sv
// ---------------------------------------------------------------------------
// lfcr_pkg
// Shared types and constants of the LED frame channel router.
// ---------------------------------------------------------------------------
package lfcr_pkg;

	localparam int BYTE_W  = 8;
	localparam int CHAN_W  = 3;
	localparam int IDX_W   = 10;
	localparam int COLOR_W = 24;
	localparam int COUNT_W = 16;
	localparam int START_W = 19;
	localparam int PIXEL_W = 16;
	localparam int LIMIT_W = 3;

	localparam int LEDS_PER_CHANNEL = 1024;
	localparam int DEF_HEADER_SLOTS = 6;
	localparam int DEF_MAX_FRAME_BYTES = 16384;

	localparam logic [BYTE_W-1:0]  HDR_END_BYTE = 8'hff;
	localparam logic [PIXEL_W-1:0] PIXEL_MAX = 16'hffff;
	localparam int SHORT_FRAME_BYTES = 4;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd1;

	localparam int PAYLOAD_W = CHAN_W + IDX_W + COLOR_W + BYTE_W;
	localparam int TDATA_W = ((PAYLOAD_W + 7) / 8) * 8;
	localparam int PAD_W = TDATA_W - PAYLOAD_W;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_DONE  = 1'b1
	} lfcr_kind_t;

	typedef struct packed {
		lfcr_kind_t          kind;
		logic [CHAN_W-1:0]   channel;
		logic [IDX_W-1:0]    led_index;
		logic [COLOR_W-1:0]  color;
		logic [BYTE_W-1:0]   motor_byte;
		logic                last;
	} lfcr_result_t;

endpackage

>>> hdl/lfcr_parser.sv
// ---------------------------------------------------------------------------
// lfcr_parser
// Frame state and per-byte decode: header counts, pixel assembly, channel
// routing and the frame done item. Gives up to two results per step.
// ---------------------------------------------------------------------------
module lfcr_parser #(
	parameter int HEADER_SLOTS = lfcr_pkg::DEF_HEADER_SLOTS,
	parameter int MAX_FRAME_BYTES = lfcr_pkg::DEF_MAX_FRAME_BYTES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic [lfcr_pkg::BYTE_W-1:0]        data_byte,
	input  logic                               frame_end,
	input  logic [lfcr_pkg::LIMIT_W-1:0]       channel_limit,
	output logic [1:0]                         res_count,
	output lfcr_pkg::lfcr_result_t [1:0]       res
);

	localparam int FB_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int HC_W = lfcr_pkg::CHAN_W;

	logic                                in_pixels_q, in_pixels_d;
	logic                                pair_half_q, pair_half_d;
	logic [lfcr_pkg::BYTE_W-1:0]         pair_low_q, pair_low_d;
	logic [HC_W-1:0]                     hc_q, hc_d;
	logic [lfcr_pkg::COUNT_W-1:0]        counts_q [HEADER_SLOTS];
	logic [lfcr_pkg::START_W-1:0]        starts_q [HEADER_SLOTS];
	logic [lfcr_pkg::START_W-1:0]        next_start_q, next_start_d;
	logic [lfcr_pkg::PIXEL_W-1:0]        pn_q, pn_d;
	logic [1:0]                          bip_q, bip_d;
	logic [15:0]                         partial_q, partial_d;
	logic [lfcr_pkg::BYTE_W-1:0]         motor_q, motor_d;
	logic [FB_W-1:0]                     fb_q, fb_d;

	logic                                hdr_wr;
	logic [lfcr_pkg::COUNT_W-1:0]        hdr_count;
	logic [lfcr_pkg::START_W-1:0]        hdr_start;

	logic [lfcr_pkg::START_W-1:0]        diff [HEADER_SLOTS];
	logic [HEADER_SLOTS-1:0]             hit;
	logic [HC_W-1:0]                     lim;
	logic                                found;
	logic [lfcr_pkg::CHAN_W-1:0]         sel_chan;
	logic [lfcr_pkg::START_W-1:0]        sel_idx;

	logic                                pix_valid;
	logic                                done_valid;
	logic [lfcr_pkg::COLOR_W-1:0]        pix_color;
	lfcr_pkg::lfcr_result_t              pix_res;
	lfcr_pkg::lfcr_result_t              done_res;

	// channel lookup for the current pixel number
	always_comb begin
		lim = (channel_limit < hc_q) ? channel_limit : hc_q;
		found = 1'b0;
		sel_chan = '0;
		sel_idx = '0;
		for (int c = 0; c < HEADER_SLOTS; c++) begin
			diff[c] = {3'b000, pn_q} - starts_q[c];
			hit[c] = (HC_W'(c) < lim) && ({3'b000, pn_q} >= starts_q[c]) &&
				(diff[c] < {3'b000, counts_q[c]});
			if (hit[c] && !found) begin
				found = 1'b1;
				sel_chan = lfcr_pkg::CHAN_W'(c);
				sel_idx = diff[c];
			end
		end
	end

	always_comb begin
		in_pixels_d = in_pixels_q;
		pair_half_d = pair_half_q;
		pair_low_d = pair_low_q;
		hc_d = hc_q;
		next_start_d = next_start_q;
		pn_d = pn_q;
		bip_d = bip_q;
		partial_d = partial_q;
		motor_d = motor_q;
		fb_d = fb_q;
		hdr_wr = 1'b0;
		hdr_count = {data_byte, pair_low_q};
		hdr_start = (hc_q == '0) ? lfcr_pkg::START_W'(1) : next_start_q;
		pix_valid = 1'b0;
		pix_color = {partial_q, data_byte};
		done_valid = 1'b0;

		if (fb_q < FB_W'(MAX_FRAME_BYTES)) begin
			fb_d = fb_q + FB_W'(1);
			if (!in_pixels_q) begin
				if (!pair_half_q) begin
					pair_low_d = data_byte;
					pair_half_d = 1'b1;
				end else begin
					pair_half_d = 1'b0;
					if (pair_low_q == lfcr_pkg::HDR_END_BYTE &&
						data_byte == lfcr_pkg::HDR_END_BYTE) begin
						in_pixels_d = 1'b1;
					end else if (hc_q < HC_W'(HEADER_SLOTS)) begin
						hdr_wr = 1'b1;
						next_start_d = hdr_start + {3'b000, hdr_count};
						hc_d = hc_q + HC_W'(1);
					end
				end
			end else begin
				case (bip_q)
					2'd0: begin
						if (pn_q == '0) begin
							motor_d = data_byte;
						end
						partial_d = {8'h00, data_byte};
						bip_d = 2'd1;
					end
					2'd1: begin
						partial_d = {partial_q[7:0], data_byte};
						bip_d = 2'd2;
					end
					default: begin
						pix_valid = (pn_q != '0) && found &&
							(sel_idx < lfcr_pkg::START_W'(lfcr_pkg::LEDS_PER_CHANNEL));
						if (pn_q != lfcr_pkg::PIXEL_MAX) begin
							pn_d = pn_q + lfcr_pkg::PIXEL_W'(1);
						end
						bip_d = 2'd0;
					end
				endcase
			end
		end

		if (frame_end) begin
			done_valid = (fb_d > FB_W'(lfcr_pkg::SHORT_FRAME_BYTES));
			in_pixels_d = 1'b0;
			pair_half_d = 1'b0;
			pair_low_d = '0;
			hc_d = '0;
			pn_d = '0;
			bip_d = '0;
			partial_d = '0;
			fb_d = '0;
		end
	end

	always_comb begin
		pix_res.kind = lfcr_pkg::KIND_PIXEL;
		pix_res.channel = sel_chan;
		pix_res.led_index = sel_idx[lfcr_pkg::IDX_W-1:0];
		pix_res.color = pix_color;
		pix_res.motor_byte = '0;
		pix_res.last = !done_valid;

		done_res.kind = lfcr_pkg::KIND_DONE;
		done_res.channel = '0;
		done_res.led_index = '0;
		done_res.color = '0;
		done_res.motor_byte = motor_d;
		done_res.last = 1'b1;

		res[0] = pix_valid ? pix_res : done_res;
		res[1] = done_res;
		res_count = step ? ({1'b0, pix_valid} + {1'b0, done_valid}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pixels_q <= 1'b0;
			pair_half_q <= 1'b0;
			pair_low_q <= '0;
			hc_q <= '0;
			next_start_q <= '0;
			pn_q <= '0;
			bip_q <= '0;
			partial_q <= '0;
			motor_q <= '0;
			fb_q <= '0;
			for (int c = 0; c < HEADER_SLOTS; c++) begin
				counts_q[c] <= '0;
				starts_q[c] <= '0;
			end
		end else if (step) begin
			in_pixels_q <= in_pixels_d;
			pair_half_q <= pair_half_d;
			pair_low_q <= pair_low_d;
			hc_q <= hc_d;
			next_start_q <= next_start_d;
			pn_q <= pn_d;
			bip_q <= bip_d;
			partial_q <= partial_d;
			motor_q <= motor_d;
			fb_q <= fb_d;
			for (int c = 0; c < HEADER_SLOTS; c++) begin
				if (hdr_wr && hc_q == HC_W'(c)) begin
					counts_q[c] <= hdr_count;
					starts_q[c] <= hdr_start;
				end
			end
		end
	end

endmodule

>>> hdl/lfcr_out_fifo.sv
// ---------------------------------------------------------------------------
// lfcr_out_fifo
// Small result queue: takes up to two results per cycle, hands out one.
// ---------------------------------------------------------------------------
module lfcr_out_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [1:0]                     push_count,
	input  lfcr_pkg::lfcr_result_t [1:0]   push_data,
	input  logic                           pop_ready,
	output logic                           room,
	output logic                           out_valid,
	output lfcr_pkg::lfcr_result_t         out_data
);

	lfcr_pkg::lfcr_result_t                mem [lfcr_pkg::FIFO_DEPTH];
	logic [lfcr_pkg::FIFO_PTR_W-1:0]       wr_ptr_q;
	logic [lfcr_pkg::FIFO_PTR_W-1:0]       rd_ptr_q;
	logic [lfcr_pkg::FIFO_CNT_W-1:0]       count_q;
	logic                                  pop;

	assign out_valid = (count_q != '0);
	assign out_data = mem[rd_ptr_q];
	assign pop = out_valid && pop_ready;
	assign room = (count_q <= lfcr_pkg::FIFO_CNT_W'(lfcr_pkg::FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem[wr_ptr_q] <= push_data[0];
		end
		if (push_count == 2'd2) begin
			mem[wr_ptr_q + lfcr_pkg::FIFO_PTR_W'(1)] <= push_data[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + lfcr_pkg::FIFO_PTR_W'(push_count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + lfcr_pkg::FIFO_PTR_W'(1);
			end
			count_q <= count_q + lfcr_pkg::FIFO_CNT_W'(push_count) -
				lfcr_pkg::FIFO_CNT_W'(pop);
		end
	end

endmodule

>>> hdl/led_frame_channel_router.sv
// ---------------------------------------------------------------------------
// led_frame_channel_router
// Routes pixel bytes of an LED frame to header channels and reports frame end.
// ---------------------------------------------------------------------------
// path: an accepted byte is registered in the input stage; when the queue has room it
//   is decoded and its results are written into the result queue
// throughput: one byte per cycle; a byte gives at most two results, drained
//   through a four-entry result queue; input stalls while a byte waits and
//   the queue holds more than two results
// reset: arst_n clears frame state, channel counts, motor byte and the queue;
//   channel_limit returns to 1
module led_frame_channel_router #(
	parameter int HEADER_SLOTS = lfcr_pkg::DEF_HEADER_SLOTS,
	parameter int MAX_FRAME_BYTES = lfcr_pkg::DEF_MAX_FRAME_BYTES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lfcr_pkg::LIMIT_W-1:0]        cfg_wdata,      // channel_limit
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [lfcr_pkg::BYTE_W-1:0]         s_axis_tdata,   // data_byte
	input  logic                                s_axis_tlast,   // frame_end
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// channel, led_index, color, motor_byte, zero pad
	output logic [lfcr_pkg::TDATA_W-1:0]        m_axis_tdata,
	output logic                                m_axis_tuser,   // kind
	output logic                                m_axis_tlast    // last
);

	logic [lfcr_pkg::LIMIT_W-1:0]     limit_q;
	logic                             vld_s1;
	logic [lfcr_pkg::BYTE_W-1:0]      byte_s1;
	logic                             end_s1;
	logic                             room;
	logic                             adv;
	logic [1:0]                       res_count;
	lfcr_pkg::lfcr_result_t [1:0]     res;
	lfcr_pkg::lfcr_result_t           out_res;

	assign adv = vld_s1 && room;
	assign s_axis_tready = !vld_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lfcr_pkg::LIMIT_RESET;
			vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			end_s1 <= s_axis_tlast;
		end
	end

	lfcr_parser #(
		.HEADER_SLOTS(HEADER_SLOTS),
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv),
		.data_byte(byte_s1),
		.frame_end(end_s1),
		.channel_limit(limit_q),
		.res_count(res_count),
		.res(res)
	);

	lfcr_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_count(res_count),
		.push_data(res),
		.pop_ready(m_axis_tready),
		.room(room),
		.out_valid(m_axis_tvalid),
		.out_data(out_res)
	);

	assign m_axis_tdata = {{lfcr_pkg::PAD_W{1'b0}}, out_res.motor_byte, out_res.color,
		out_res.led_index, out_res.channel};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last;

endmodule
